// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// shared types, constants and helpers of the three level cache tag model
// ----------------------------------------------------------------------------
package cts_pkg;

  // block number bits (byte address without the 64 byte offset)
  localparam int BLK_W     = 26;
  localparam int ADDR_W    = 32;
  localparam int BLK_SHIFT = 6;
  localparam int SET_W     = 14;
  localparam int CNT_W     = 48;
  localparam int LAT_W     = 16;
  localparam int COST_W    = 18;
  localparam int CFG_IDX_W = 3;

  localparam int FIRST_SETS_DEF  = 8;
  localparam int FIRST_WAYS_DEF  = 2;
  localparam int SECOND_SETS_DEF = 16;
  localparam int SECOND_WAYS_DEF = 4;
  localparam int THIRD_SETS_DEF  = 32;
  localparam int THIRD_WAYS_DEF  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_LAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_LAT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_POL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_POL   = 3'd6;

  // where a request was served
  localparam logic [1:0] LVL_FIRST  = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_THIRD  = 2'd2;
  localparam logic [1:0] LVL_MEMORY = 2'd3;

  // statistics counter slots
  localparam logic [2:0] CNT_REQ = 3'd6;
  localparam logic [2:0] CNT_CYC = 3'd7;

  // replacement policy codes
  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_FIFO = 1'b1;

  typedef struct packed {
    logic [LAT_W-1:0] lat_first;
    logic [LAT_W-1:0] lat_second;
    logic [LAT_W-1:0] lat_third;
    logic [LAT_W-1:0] lat_mem;
    logic [2:0]       pol;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [SET_W-1:0] set_first;
    logic [SET_W-1:0] set_second;
    logic [SET_W-1:0] set_third;
  } req_t;

  typedef struct packed {
    logic [1:0]        hit_level;
    logic [COST_W-1:0] access_cost;
    logic [CNT_W-1:0]  request_count;
    logic [CNT_W-1:0]  cycle_total;
    logic [CNT_W-1:0]  first_hits;
    logic [CNT_W-1:0]  first_misses;
    logic [CNT_W-1:0]  second_hits;
    logic [CNT_W-1:0]  second_misses;
    logic [CNT_W-1:0]  third_hits;
    logic [CNT_W-1:0]  third_misses;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/cts_ram.sv =====
// ----------------------------------------------------------------------------
// cts_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cts_level.sv =====
// ----------------------------------------------------------------------------
// cts_level
// one set associative tag level: row read, hit check, victim pick, rank update
// ----------------------------------------------------------------------------
module cts_level #(
  parameter int SETS = 8,
  parameter int WAYS = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        lookup,
  input  logic                        commit,
  input  logic [cts_pkg::SET_W-1:0]   set_in,
  input  logic [cts_pkg::BLK_W-1:0]   blk,
  input  logic                        policy,
  output logic                        hit
);

  localparam int SW  = SETS > 1 ? $clog2(SETS) : 1;
  localparam int WW  = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int RB  = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int EW  = cts_pkg::BLK_W + 2 * RB;
  localparam int ROW = WAYS * EW;

  typedef logic [WAYS-1:0][RB-1:0] rk_t;

  logic [SETS-1:0][WAYS-1:0] vld;
  logic [SW-1:0]             set_idx;
  logic [ROW-1:0]            row;
  logic [ROW-1:0]            row_next;
  logic [WAYS-1:0]           v;
  logic [WAYS-1:0][cts_pkg::BLK_W-1:0] tg;
  rk_t                       ur;
  rk_t                       fr;
  rk_t                       ur_next;
  rk_t                       fr_next;
  logic                      found;
  logic                      pick;
  logic [WW-1:0]             hw;
  logic [WW-1:0]             vic;
  logic [WW-1:0]             w;

  // move way w to the newest rank among valid ways
  function automatic rk_t touch(rk_t r, logic [WAYS-1:0] vv, logic [WW-1:0] wi);
    rk_t          o;
    logic [RB-1:0] others;
    o      = r;
    others = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (WW'(i) != wi && vv[i]) begin
        others = others + RB'(1);
        if (vv[wi] && r[i] > r[wi]) begin
          o[i] = r[i] - RB'(1);
        end
      end
    end
    o[wi] = others;
    return o;
  endfunction

  assign set_idx = set_in[SW-1:0];
  assign v       = vld[set_idx];

  cts_ram #(.WIDTH(ROW), .DEPTH(SETS)) u_tags (
    .clk   (clk),
    .we    (commit),
    .waddr (set_idx),
    .wdata (row_next),
    .raddr (set_idx),
    .rdata (row)
  );

  always_comb begin
    hit   = 1'b0;
    hw    = '0;
    found = 1'b0;
    vic   = '0;
    pick  = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      tg[i] = row[i*EW + 2*RB +: cts_pkg::BLK_W];
      ur[i] = row[i*EW + RB +: RB];
      fr[i] = row[i*EW +: RB];
    end
    for (int i = 0; i < WAYS; i++) begin
      if (v[i] && tg[i] == blk && !hit) begin
        hit = 1'b1;
        hw  = WW'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!v[i] && !found) begin
        found = 1'b1;
        vic   = WW'(i);
      end
    end
    if (!found) begin
      for (int i = 0; i < WAYS; i++) begin
        if (((policy == cts_pkg::POL_FIFO) ? fr[i] : ur[i]) == '0 && !pick) begin
          pick = 1'b1;
          vic  = WW'(i);
        end
      end
    end
    w       = hit ? hw : vic;
    ur_next = (hit && policy == cts_pkg::POL_FIFO) ? ur : touch(ur, v, w);
    fr_next = hit ? fr : touch(fr, v, w);
    for (int i = 0; i < WAYS; i++) begin
      row_next[i*EW +: EW] = {((WW'(i) == w && !hit) ? blk : tg[i]), ur_next[i], fr_next[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (commit && !hit) begin
      vld[set_idx][w] <= 1'b1;
    end
  end

  // lookup is always the cycle before commit
  a_commit_after_lookup: assert property (@(posedge clk) disable iff (rst)
    commit |-> $past(lookup))
    else $error("commit without a preceding lookup");

  a_no_lookup_commit: assert property (@(posedge clk) disable iff (rst)
    !(lookup && commit))
    else $error("lookup and commit together");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    commit && !hit |=> vld[$past(set_idx)][$past(w)])
    else $error("filled way not valid");

endmodule

// ===== hw/rtl/cts_front.sv =====
// ----------------------------------------------------------------------------
// cts_front
// accepts addresses, derives block and set indexes, queues them for the back
// ----------------------------------------------------------------------------
module cts_front #(
  parameter int FIRST_SETS  = cts_pkg::FIRST_SETS_DEF,
  parameter int SECOND_SETS = cts_pkg::SECOND_SETS_DEF,
  parameter int THIRD_SETS  = cts_pkg::THIRD_SETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cts_pkg::ADDR_W-1:0]   byte_address,
  output logic                         q_valid,
  output cts_pkg::req_t                q_head,
  input  logic                         q_pop
);

  // reciprocal of a set count, scaled so that the quotient estimate is at
  // most one below the true quotient for any block number
  function automatic logic [27:0] recip(int d);
    longint unsigned p;
    p = 64'd1 << (cts_pkg::BLK_W + $clog2(d));
    return 28'(p / 64'(d));
  endfunction

  localparam bit ALL_POW2 = ((FIRST_SETS & (FIRST_SETS - 1)) == 0)
                         && ((SECOND_SETS & (SECOND_SETS - 1)) == 0)
                         && ((THIRD_SETS & (THIRD_SETS - 1)) == 0);
  localparam int NSTEP = 3;
  localparam int SW1 = cts_pkg::SET_W + 1;
  localparam int PW  = cts_pkg::BLK_W + 28;
  localparam logic [27:0] RCP [3] = '{recip(FIRST_SETS), recip(SECOND_SETS),
                                      recip(THIRD_SETS)};
  localparam int SHR [3] = '{cts_pkg::BLK_W + $clog2(FIRST_SETS),
                             cts_pkg::BLK_W + $clog2(SECOND_SETS),
                             cts_pkg::BLK_W + $clog2(THIRD_SETS)};

  logic                        busy;
  logic [1:0]                  cnt;
  logic [cts_pkg::BLK_W-1:0]   blk;
  logic [cts_pkg::BLK_W-1:0]   in_blk;
  logic [2:0][cts_pkg::SET_W-1:0] rem;
  logic [2:0][cts_pkg::SET_W-1:0] rem_next;
  logic [2:0][SW1-1:0]         divs;
  logic [2:0][PW-1:0]          prod;
  logic [2:0][cts_pkg::BLK_W-1:0] qe;
  logic [2:0][cts_pkg::BLK_W-1:0] qe_next;
  logic [2:0][SW1-1:0]         rw;
  logic [2:0][SW1-1:0]         rw_next;
  logic                        done;
  logic                        push;
  cts_pkg::req_t               q [2];
  logic                        wp;
  logic                        rp;
  logic [1:0]                  fill;

  assign in_blk  = byte_address[cts_pkg::ADDR_W-1:cts_pkg::BLK_SHIFT];
  assign in_stall = busy;
  assign divs[0] = SW1'(FIRST_SETS);
  assign divs[1] = SW1'(SECOND_SETS);
  assign divs[2] = SW1'(THIRD_SETS);
  assign done    = ALL_POW2 || cnt == 2'(NSTEP);
  assign push    = busy && done && fill != 2'd2;

  // set index by reciprocal multiply, multiply-subtract, then one correction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]     = PW'(blk) * PW'(RCP[k]);
      qe_next[k]  = cts_pkg::BLK_W'(prod[k] >> SHR[k]);
      rw_next[k]  = SW1'(blk - cts_pkg::BLK_W'(qe[k] * cts_pkg::BLK_W'(divs[k])));
      rem_next[k] = (rw[k] >= divs[k]) ? cts_pkg::SET_W'(rw[k] - divs[k])
                                       : cts_pkg::SET_W'(rw[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && !in_stall) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && !done) begin
      cnt <= cnt + 2'd1;
    end else if (push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      blk <= in_blk;
      if (ALL_POW2) begin
        rem[0] <= cts_pkg::SET_W'(in_blk & cts_pkg::BLK_W'(FIRST_SETS - 1));
        rem[1] <= cts_pkg::SET_W'(in_blk & cts_pkg::BLK_W'(SECOND_SETS - 1));
        rem[2] <= cts_pkg::SET_W'(in_blk & cts_pkg::BLK_W'(THIRD_SETS - 1));
      end else begin
        rem <= '0;
      end
    end else if (busy && !done) begin
      case (cnt)
        2'd0: begin
          qe <= qe_next;
        end
        2'd1: begin
          rw <= rw_next;
        end
        default: begin
          rem <= rem_next;
        end
      endcase
    end
  end

  // two entry queue toward the back
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{blk: blk, set_first: rem[0], set_second: rem[1], set_third: rem[2]};
    end
  end

  assign q_valid = fill != 2'd0;
  assign q_head  = q[rp];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2)
    else $error("queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill != 2'd0)
    else $error("pop from empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> busy)
    else $error("accepted item lost");

endmodule

// ===== hw/rtl/cts_back.sv =====
// ----------------------------------------------------------------------------
// cts_back
// walks the three levels for one request, keeps statistics, holds the result
// ----------------------------------------------------------------------------
module cts_back #(
  parameter int FIRST_SETS  = cts_pkg::FIRST_SETS_DEF,
  parameter int FIRST_WAYS  = cts_pkg::FIRST_WAYS_DEF,
  parameter int SECOND_SETS = cts_pkg::SECOND_SETS_DEF,
  parameter int SECOND_WAYS = cts_pkg::SECOND_WAYS_DEF,
  parameter int THIRD_SETS  = cts_pkg::THIRD_SETS_DEF,
  parameter int THIRD_WAYS  = cts_pkg::THIRD_WAYS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cts_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  cts_pkg::req_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output cts_pkg::res_t  res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                          state;
  cts_pkg::req_t                   item;
  logic [1:0]                      lvl;
  logic [1:0]                      where;
  logic [cts_pkg::COST_W-1:0]      cost;
  logic [cts_pkg::COST_W-1:0]      cost_add;
  logic [7:0][cts_pkg::CNT_W-1:0]  cnt;
  logic [2:0]                      look;
  logic [2:0]                      commit;
  logic [2:0]                      hits;
  logic                            cur_hit;
  logic [cts_pkg::LAT_W-1:0]       lat;
  logic                            out_free;
  logic [cts_pkg::CNT_W-1:0]       req_next;
  logic [cts_pkg::CNT_W-1:0]       cyc_next;

  always_comb begin
    case (lvl)
      cts_pkg::LVL_FIRST:  lat = cfg.lat_first;
      cts_pkg::LVL_SECOND: lat = cfg.lat_second;
      default:             lat = cfg.lat_third;
    endcase
  end

  assign look     = (state == S_LOOK) ? 3'(1) << lvl : 3'b000;
  assign commit   = (state == S_EVAL) ? 3'(1) << lvl : 3'b000;
  assign cur_hit  = hits[lvl];
  assign cost_add = cost + cts_pkg::COST_W'(lat);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign req_next = cts_pkg::sat_add(cnt[cts_pkg::CNT_REQ], cts_pkg::CNT_W'(1));
  assign cyc_next = cts_pkg::sat_add(cnt[cts_pkg::CNT_CYC], cts_pkg::CNT_W'(cost));

  cts_level #(.SETS(FIRST_SETS), .WAYS(FIRST_WAYS)) u_first (
    .clk (clk), .rst (rst), .lookup (look[0]), .commit (commit[0]),
    .set_in (item.set_first), .blk (item.blk), .policy (cfg.pol[0]), .hit (hits[0])
  );

  cts_level #(.SETS(SECOND_SETS), .WAYS(SECOND_WAYS)) u_second (
    .clk (clk), .rst (rst), .lookup (look[1]), .commit (commit[1]),
    .set_in (item.set_second), .blk (item.blk), .policy (cfg.pol[1]), .hit (hits[1])
  );

  cts_level #(.SETS(THIRD_SETS), .WAYS(THIRD_WAYS)) u_third (
    .clk (clk), .rst (rst), .lookup (look[2]), .commit (commit[2]),
    .set_in (item.set_third), .blk (item.blk), .policy (cfg.pol[2]), .hit (hits[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            lvl   <= cts_pkg::LVL_FIRST;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cur_hit) begin
            cnt[{lvl, 1'b0}] <= cts_pkg::sat_add(cnt[{lvl, 1'b0}], cts_pkg::CNT_W'(1));
            state <= S_DONE;
          end else begin
            cnt[{lvl, 1'b1}] <= cts_pkg::sat_add(cnt[{lvl, 1'b1}], cts_pkg::CNT_W'(1));
            if (lvl == cts_pkg::LVL_THIRD) begin
              state <= S_DONE;
            end else begin
              lvl   <= lvl + 2'd1;
              state <= S_LOOK;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            cnt[cts_pkg::CNT_REQ] <= req_next;
            cnt[cts_pkg::CNT_CYC] <= cyc_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= q_head;
        cost <= '0;
      end
      S_EVAL: begin
        if (cur_hit) begin
          cost  <= cost_add;
          where <= lvl;
        end else if (lvl == cts_pkg::LVL_THIRD) begin
          cost  <= cost_add + cts_pkg::COST_W'(cfg.lat_mem);
          where <= cts_pkg::LVL_MEMORY;
        end else begin
          cost <= cost_add;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res <= '{hit_level: where, access_cost: cost,
                   request_count: req_next, cycle_total: cyc_next,
                   first_hits: cnt[0], first_misses: cnt[1],
                   second_hits: cnt[2], second_misses: cnt[3],
                   third_hits: cnt[4], third_misses: cnt[5]};
        end
      end
      default: begin
      end
    endcase
  end

  a_look_then_eval: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |=> state == S_EVAL)
    else $error("lookup not followed by evaluation");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_cost_starts_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL && lvl == cts_pkg::LVL_FIRST |-> cost == '0)
    else $error("cost not cleared at request start");

  a_no_fourth_level: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> lvl != cts_pkg::LVL_MEMORY)
    else $error("walk past the third level");

endmodule

// ===== hw/rtl/three_level_cache_tag_model.sv =====
// ----------------------------------------------------------------------------
// three_level_cache_tag_model
// tag only model of a three level set associative cache with statistics
// ----------------------------------------------------------------------------
// Each transfer on the input carries one byte address; each result transfer
// reports the level that served it, the access cost summed from the latency
// registers, and saturating hit, miss, request and cycle counters. The front
// splits the address into its 64 byte block number and the set index of each
// level: with power of two set counts the indexes are masked off as the
// address is registered, otherwise a reciprocal multiply, a multiply-subtract
// and a correcting subtract follow as registered steps. A two entry queue
// hands the request to the back, which visits the levels in order, with a
// lookup state and an evaluation state per level consulted (registered read
// of the set row from the tag ram, then hit check, victim pick and rank write
// back), plus an idle state that picks up the item and a done state that
// loads the result register. With power of two set counts the front runs
// ahead, so the sustained rate is set by the back's level walk. Valid bits sit
// in flip-flops and are cleared by reset, so no clearing pass is needed.
// Configuration writes are always accepted (cfg_ready is high) and must only
// be made while no request is in flight; indexes past the list are ignored.
// ----------------------------------------------------------------------------
module three_level_cache_tag_model #(
  parameter int FIRST_SETS  = cts_pkg::FIRST_SETS_DEF,
  parameter int FIRST_WAYS  = cts_pkg::FIRST_WAYS_DEF,
  parameter int SECOND_SETS = cts_pkg::SECOND_SETS_DEF,
  parameter int SECOND_WAYS = cts_pkg::SECOND_WAYS_DEF,
  parameter int THIRD_SETS  = cts_pkg::THIRD_SETS_DEF,
  parameter int THIRD_WAYS  = cts_pkg::THIRD_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cts_pkg::ADDR_W-1:0]      byte_address,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      hit_level,
  output logic [cts_pkg::COST_W-1:0]      access_cost,
  output logic [cts_pkg::CNT_W-1:0]       request_count,
  output logic [cts_pkg::CNT_W-1:0]       cycle_total,
  output logic [cts_pkg::CNT_W-1:0]       first_hits,
  output logic [cts_pkg::CNT_W-1:0]       first_misses,
  output logic [cts_pkg::CNT_W-1:0]       second_hits,
  output logic [cts_pkg::CNT_W-1:0]       second_misses,
  output logic [cts_pkg::CNT_W-1:0]       third_hits,
  output logic [cts_pkg::CNT_W-1:0]       third_misses,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cts_pkg::LAT_W-1:0]       cfg_data
);

  cts_pkg::cfg_t  cfg;
  cts_pkg::req_t  q_head;
  cts_pkg::res_t  res;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers, values masked to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_first  <= 16'd1;
      cfg.lat_second <= 16'd10;
      cfg.lat_third  <= 16'd40;
      cfg.lat_mem    <= 16'd200;
      cfg.pol        <= {cts_pkg::POL_FIFO, cts_pkg::POL_LRU, cts_pkg::POL_LRU};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cts_pkg::REG_FIRST_LAT:  cfg.lat_first  <= cfg_data;
        cts_pkg::REG_SECOND_LAT: cfg.lat_second <= cfg_data;
        cts_pkg::REG_THIRD_LAT:  cfg.lat_third  <= cfg_data;
        cts_pkg::REG_MEM_LAT:    cfg.lat_mem    <= cfg_data;
        cts_pkg::REG_FIRST_POL:  cfg.pol[0]     <= cfg_data[0];
        cts_pkg::REG_SECOND_POL: cfg.pol[1]     <= cfg_data[0];
        cts_pkg::REG_THIRD_POL:  cfg.pol[2]     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: address split and queue
  cts_front #(
    .FIRST_SETS  (FIRST_SETS),
    .SECOND_SETS (SECOND_SETS),
    .THIRD_SETS  (THIRD_SETS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_address (byte_address),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  // back: level walk, statistics and result register
  cts_back #(
    .FIRST_SETS  (FIRST_SETS),
    .FIRST_WAYS  (FIRST_WAYS),
    .SECOND_SETS (SECOND_SETS),
    .SECOND_WAYS (SECOND_WAYS),
    .THIRD_SETS  (THIRD_SETS),
    .THIRD_WAYS  (THIRD_WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign hit_level     = res.hit_level;
  assign access_cost   = res.access_cost;
  assign request_count = res.request_count;
  assign cycle_total   = res.cycle_total;
  assign first_hits    = res.first_hits;
  assign first_misses  = res.first_misses;
  assign second_hits   = res.second_hits;
  assign second_misses = res.second_misses;
  assign third_hits    = res.third_hits;
  assign third_misses  = res.third_misses;

endmodule
